>>> rtl/core/tld_pkg.sv
// Shared types, register codes and reset values for the tremor level detector.
// No dependencies.
package tld_pkg;

	localparam int AXIS_W = 24;
	localparam int SQ_W   = 50;
	localparam int WGT_W  = 16;
	localparam int IDX_W  = 3;
	localparam int QDEPTH = 2;

	typedef logic signed [AXIS_W-1:0] axis_t;

	typedef struct packed {
		axis_t x;
		axis_t y;
		axis_t z;
	} smp_t;

	typedef struct packed {
		logic [WGT_W-1:0] weight;
		logic [SQ_W-1:0]  light_low;
		logic [SQ_W-1:0]  strong_low;
		logic [SQ_W-1:0]  strong_high;
		logic [SQ_W-1:0]  alert;
	} cfg_t;

	typedef enum logic [IDX_W-1:0] {
		CFG_WEIGHT      = 3'd0,
		CFG_LIGHT_LOW   = 3'd1,
		CFG_STRONG_LOW  = 3'd2,
		CFG_STRONG_HIGH = 3'd3,
		CFG_ALERT       = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LVL_NONE   = 2'd0,
		LVL_LIGHT  = 2'd1,
		LVL_STRONG = 2'd2,
		LVL_ALERT  = 2'd3
	} lvl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_SQR,
		ST_SUM
	} st_t;

	localparam logic [WGT_W-1:0] RST_WEIGHT      = 16'd13107;
	localparam logic [SQ_W-1:0]  RST_LIGHT_LOW   = 50'd429497;
	localparam logic [SQ_W-1:0]  RST_STRONG_LOW  = 50'd3865470;
	localparam logic [SQ_W-1:0]  RST_STRONG_HIGH = 50'd10737418;
	localparam logic [SQ_W-1:0]  RST_ALERT       = 50'd1073741824;

	localparam logic signed [31:0] AXIS_MAX = 32'sd8388607;
	localparam logic signed [31:0] AXIS_MIN = -32'sd8388608;

	function automatic axis_t sat24(input logic signed [31:0] v);
		axis_t r;
		if (v > AXIS_MAX) begin
			r = axis_t'(AXIS_MAX);
		end else if (v < AXIS_MIN) begin
			r = axis_t'(AXIS_MIN);
		end else begin
			r = axis_t'(v);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/tld_front.sv
// Input side: takes raw samples, scales them to filter units with saturation.
// Depends on tld_pkg; feeds tld_queue.
module tld_front import tld_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_x,
	input  logic signed [15:0] sample_y,
	input  logic signed [15:0] sample_z,
	input  logic               full,
	output logic               push,
	output smp_t               push_data
);

	function automatic axis_t scale(input logic signed [15:0] s);
		logic signed [31:0] w;
		w = 32'(s) <<< FRACTION_BITS;
		return sat24(w);
	endfunction

	assign in_ready    = !full;
	assign push        = in_valid && !full;
	assign push_data.x = scale(sample_x);
	assign push_data.y = scale(sample_y);
	assign push_data.z = scale(sample_z);

endmodule

>>> rtl/core/tld_queue.sv
// Two-entry queue of scaled samples between front and back.
// Depends on tld_pkg.
module tld_queue import tld_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  smp_t push_data,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output smp_t head
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	smp_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue pop while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

>>> rtl/core/tld_back.sv
// Back end: three filter lanes, XY change squaring, classification, output register.
// Depends on tld_pkg; pulls items from tld_queue.
module tld_back import tld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  smp_t        head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  tremor_level,
	output logic [49:0] lateral_change_sq,
	output axis_t       smoothed_x,
	output axis_t       smoothed_y,
	output axis_t       smoothed_z
);

	st_t st_q, st_d;
	logic upd_en, sqr_en, load, out_free;

	axis_t              old_q   [3];
	axis_t              s_in    [3];
	logic signed [24:0] dv      [3];
	logic signed [41:0] prod    [3];
	logic signed [41:0] prod_s1 [3];
	logic signed [42:0] acc     [3];
	axis_t              nv      [3];
	logic signed [24:0] d_s2    [2];
	logic signed [49:0] sq      [2];
	logic [48:0]        sq_s3   [2];
	logic signed [16:0] wv;
	logic [49:0]        qsum;
	lvl_t               lvl;

	lvl_t  lvl_q;
	logic  out_valid_q;
	logic [49:0] q_q;
	axis_t ox_q, oy_q, oz_q;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: st_d = q_valid ? ST_UPD : ST_IDLE;
			ST_UPD:  st_d = ST_SQR;
			ST_SQR:  st_d = ST_SUM;
			ST_SUM: begin
				if (!out_free) begin
					st_d = ST_SUM;
				end else if (q_valid) begin
					st_d = ST_UPD;
				end else begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		upd_en = 1'b0;
		sqr_en = 1'b0;
		load   = 1'b0;
		unique case (st_q)
			ST_IDLE: pop = q_valid;
			ST_UPD:  upd_en = 1'b1;
			ST_SQR:  sqr_en = 1'b1;
			ST_SUM: begin
				load = out_free;
				pop  = out_free && q_valid;
			end
			default: pop = 1'b0;
		endcase
	end

	assign s_in[0] = head.x;
	assign s_in[1] = head.y;
	assign s_in[2] = head.z;
	assign wv      = signed'({1'b0, cfg.weight});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv[i]   = 25'(s_in[i]) - 25'(old_q[i]);
			prod[i] = dv[i] * wv;
			acc[i]  = (43'(old_q[i]) <<< 16) + 43'(prod_s1[i]) + 43'sd32768;
			nv[i]   = sat24(32'(acc[i] >>> 16));
		end
		for (int j = 0; j < 2; j++) begin
			sq[j] = 50'(d_s2[j]) * 50'(d_s2[j]);
		end
	end

	assign qsum = 50'(sq_s3[0]) + 50'(sq_s3[1]);

	always_comb begin
		priority if (qsum > cfg.light_low && qsum < cfg.strong_low) begin
			lvl = LVL_LIGHT;
		end else if (qsum >= cfg.strong_low && qsum < cfg.strong_high) begin
			lvl = LVL_STRONG;
		end else if (qsum >= cfg.alert) begin
			lvl = LVL_ALERT;
		end else begin
			lvl = LVL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				old_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (upd_en) begin
				for (int i = 0; i < 3; i++) begin
					old_q[i] <= nv[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= prod[i];
			end
		end
		if (upd_en) begin
			for (int j = 0; j < 2; j++) begin
				d_s2[j] <= 25'(nv[j]) - 25'(old_q[j]);
			end
		end
		if (sqr_en) begin
			for (int j = 0; j < 2; j++) begin
				sq_s3[j] <= sq[j][48:0];
			end
		end
		if (load) begin
			lvl_q <= lvl;
			q_q   <= qsum;
			ox_q  <= old_q[0];
			oy_q  <= old_q[1];
			oz_q  <= old_q[2];
		end
	end

	assign out_valid         = out_valid_q;
	assign tremor_level      = lvl_q;
	assign lateral_change_sq = q_q;
	assign smoothed_x        = ox_q;
	assign smoothed_y        = oy_q;
	assign smoothed_z        = oz_q;

	a_pop_state: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (st_q == ST_IDLE || st_q == ST_SUM))
		else $error("item taken outside idle or finish step");

	a_pop_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> st_q == ST_UPD)
		else $error("taken item not carried into update step");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before delivery");

endmodule

>>> rtl/core/tremor_level_detector_core.sv
// Tremor level detector top level: configuration registers, front, queue and back.
// Depends on tld_pkg, tld_front, tld_queue, tld_back.
//
// Input channel (in_valid/in_ready): one signed X/Y/Z sample in counts of 1/256 g.
// Output channel (out_valid/out_ready): one result per sample: tremor level,
// squared XY change of the filtered values and the three filtered axes.
// Configuration: cfg_we writes cfg_data into register cfg_index at a clock edge;
// index 0 smoothing weight, 1..4 squared thresholds. Other indexes are ignored.
// Write only while no item is in flight.
//
// An accepted sample passes through the queue into the back end, whose sequencer
// runs update, square and classify steps for one item at a time, so it takes the
// next item only as the last one is loaded into the output register.
// A two-entry queue buffers scaled samples, so input keeps being accepted
// while the back end works or while a result waits on out_ready.
// When the receiver stalls, the result is held and the back end waits in its
// last step; once the queue fills, in_ready drops.
// Reset clears filter state to zero and loads the default thresholds and weight.
module tremor_level_detector_core import tld_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_x,
	input  logic signed [15:0] sample_y,
	input  logic signed [15:0] sample_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         tremor_level,
	output logic [49:0]        lateral_change_sq,
	output logic signed [23:0] smoothed_x,
	output logic signed [23:0] smoothed_y,
	output logic signed [23:0] smoothed_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [49:0]        cfg_data
);

	cfg_t cfg_q;
	logic push, pop, full, nonempty;
	smp_t push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight      <= RST_WEIGHT;
			cfg_q.light_low   <= RST_LIGHT_LOW;
			cfg_q.strong_low  <= RST_STRONG_LOW;
			cfg_q.strong_high <= RST_STRONG_HIGH;
			cfg_q.alert       <= RST_ALERT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WEIGHT:      cfg_q.weight      <= cfg_data[WGT_W-1:0];
				CFG_LIGHT_LOW:   cfg_q.light_low   <= cfg_data;
				CFG_STRONG_LOW:  cfg_q.strong_low  <= cfg_data;
				CFG_STRONG_HIGH: cfg_q.strong_high <= cfg_data;
				CFG_ALERT:       cfg_q.alert       <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	tld_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample_x (sample_x),
		.sample_y (sample_y),
		.sample_z (sample_z),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	tld_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	tld_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (nonempty),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.tremor_level     (tremor_level),
		.lateral_change_sq(lateral_change_sq),
		.smoothed_x       (smoothed_x),
		.smoothed_y       (smoothed_y),
		.smoothed_z       (smoothed_z)
	);

endmodule
